FILE: rtl/core/lphs_pkg.sv
// lphs_pkg: shared types and constants of the linear probing hash set
// word formats, status codes, command codes and parameter defaults
// no dependencies
package lphs_pkg;

	// fixed field widths of the request and response words
	localparam int CMD_W     = 1;
	localparam int KEY_IN_W  = 32;
	localparam int HASH_W    = 32;
	localparam int STATUS_W  = 3;
	localparam int SLOT_W    = 10;
	localparam int CNT_OUT_W = 11;
	localparam int MAXC_W    = 11;

	// parameter defaults
	localparam int TABLE_DEPTH_DEF = 1024;
	localparam int KEY_WIDTH_DEF   = 32;

	// load limit after reset
	localparam logic [MAXC_W-1:0] MAX_COUNT_RESET = MAXC_W'(768);

	// command codes
	localparam logic [CMD_W-1:0] CMD_LOOKUP = 1'b0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_MISS     = 3'd0;
	localparam logic [STATUS_W-1:0] ST_HIT      = 3'd1;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;

	// request word
	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [KEY_IN_W-1:0] key;
		logic [HASH_W-1:0]   hash;
	} req_t;

	// response word
	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    slot;
		logic [CNT_OUT_W-1:0] entry_count;
	} rsp_t;

endpackage

FILE: rtl/core/lphs_ram.sv
// lphs_ram: generic simple dual port ram, one write and one registered read
// no dependencies
module lphs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/linear_probe_hash_set_unit.sv
// A zero key or a lookup on an empty set answers in the cycle after start.
// Otherwise the hash is reduced (quotient, remainder, correction) if TABLE_DEPTH is not
// a power of two, then S_LOAD and S_CHECK run, the result registered from the last check.
// One item at a time: busy stays high until the result is shown, with one memory read
// per probe. Results cannot be stalled.
// After reset a sweep clears every slot of the store with busy high; config writes go on.
// linear_probe_hash_set_unit: open addressing hash set with linear probing
// depends on lphs_pkg and lphs_ram
module linear_probe_hash_set_unit
	import lphs_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
	parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MAXC_W-1:0] cfg_data
);

	localparam int IDX_W   = $clog2(TABLE_DEPTH);
	localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
	localparam int CMP_W   = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
	localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;
	localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W:0]    DEPTH_EXT = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [HASH_W-1:0] DEPTH_MUL = HASH_W'(TABLE_DEPTH);
	localparam logic [HASH_W-1:0] RECIP     = HASH_W'((64'd1 << HASH_W) / TABLE_DEPTH);

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLEAR  = 3'd1;
	localparam logic [2:0] S_REDUCE = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_CHECK  = 3'd4;

	// hash reduction steps
	localparam logic [1:0] PH_QUOT = 2'd0;
	localparam logic [1:0] PH_REM  = 2'd1;
	localparam logic [1:0] PH_FIX  = 2'd2;

	logic [2:0]           state_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     n_q;
	logic [1:0]           phase_q;
	logic [CNT_W-1:0]     count_q;
	logic [MAXC_W-1:0]    max_count_q;
	logic                 done_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CMD_W-1:0]     cmd_q;
	logic [HASH_W-1:0]    hash_q;
	logic [HASH_W-1:0]    quot_q;
	logic [IDX_W:0]       rem_q;
	rsp_t                 rsp_q;

	logic                 accept;
	logic [KEY_WIDTH-1:0] key_in;
	logic                 early;
	logic [IDX_W-1:0]     idx_next;
	logic [HASH_W-1:0]    mul_a;
	logic [HASH_W-1:0]    mul_b;
	logic [2*HASH_W-1:0]  mul_p;
	logic [IDX_W-1:0]     rem_fix;
	logic [KEY_WIDTH-1:0] rd_key;
	logic                 hit;
	logic                 empty;
	logic                 last;
	logic                 at_limit;
	logic                 ins_ok;
	logic                 finish;
	logic                 ram_we;
	logic [KEY_WIDTH-1:0] ram_wdata;
	logic [IDX_W-1:0]     ram_raddr;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	// key store, cleared after reset by the sweep
	lphs_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(TABLE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(idx_q),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(rd_key)
	);

	// probe decisions, shared multiplier and memory control
	always_comb begin
		accept    = start && !busy;
		key_in    = KEY_WIDTH'(req.key);
		early     = (key_in == '0) || ((req.command == CMD_LOOKUP) && (count_q == '0));
		idx_next  = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
		mul_a     = (phase_q == PH_QUOT) ? hash_q : quot_q;
		mul_b     = (phase_q == PH_QUOT) ? RECIP : DEPTH_MUL;
		mul_p     = (2*HASH_W)'(mul_a) * (2*HASH_W)'(mul_b);
		rem_fix   = (rem_q >= DEPTH_EXT) ? IDX_W'(rem_q - DEPTH_EXT) : IDX_W'(rem_q);
		hit       = (rd_key == key_q);
		empty     = (rd_key == '0);
		last      = (n_q == LAST_IDX);
		at_limit  = CMP_W'(count_q) >= CMP_W'(max_count_q);
		ins_ok    = (cmd_q == CMD_INSERT) && empty && !hit && !at_limit;
		finish    = hit || empty || last;
		ram_we    = (state_q == S_CLEAR) || ((state_q == S_CHECK) && ins_ok);
		ram_wdata = (state_q == S_CLEAR) ? '0 : key_q;
		ram_raddr = (state_q == S_CHECK) ? idx_next : idx_q;
	end

	// sequencer, counters and config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			idx_q       <= '0;
			n_q         <= '0;
			phase_q     <= '0;
			count_q     <= '0;
			max_count_q <= MAX_COUNT_RESET;
			done_q      <= 1'b0;
		end else begin
			done_q <= (accept && early) || ((state_q == S_CHECK) && finish);
			if (cfg_valid && cfg_ready) begin
				max_count_q <= cfg_data;
			end
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_next;
					if (idx_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept && !early) begin
						if (IS_POW2) begin
							idx_q   <= req.hash[IDX_W-1:0];
							state_q <= S_LOAD;
						end else begin
							phase_q <= PH_QUOT;
							state_q <= S_REDUCE;
						end
					end
				end
				S_REDUCE: begin
					// quotient by reciprocal, remainder, then one correction
					phase_q <= phase_q + 1'b1;
					if (phase_q == PH_FIX) begin
						idx_q   <= rem_fix;
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					n_q     <= '0;
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (finish) begin
						state_q <= S_IDLE;
						if (ins_ok) begin
							count_q <= count_q + 1'b1;
						end
					end else begin
						idx_q <= idx_next;
						n_q   <= n_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture, hash reduction and response word
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q  <= key_in;
			cmd_q  <= req.command;
			hash_q <= req.hash;
			if (early) begin
				rsp_q.status      <= (req.command == CMD_INSERT) ? ST_REJECTED : ST_MISS;
				rsp_q.slot        <= '0;
				rsp_q.entry_count <= CNT_OUT_W'(count_q);
			end
		end
		// quotient estimate is low by at most one, so the remainder stays below twice the depth
		if ((state_q == S_REDUCE) && (phase_q == PH_QUOT)) begin
			quot_q <= mul_p[2*HASH_W-1:HASH_W];
		end
		if ((state_q == S_REDUCE) && (phase_q == PH_REM)) begin
			rem_q <= (IDX_W + 1)'(hash_q - mul_p[HASH_W-1:0]);
		end
		if ((state_q == S_CHECK) && finish) begin
			if (hit) begin
				rsp_q.status      <= (cmd_q == CMD_INSERT) ? ST_PRESENT : ST_HIT;
				rsp_q.slot        <= SLOT_W'(idx_q);
				rsp_q.entry_count <= CNT_OUT_W'(count_q);
			end else if (ins_ok) begin
				rsp_q.status      <= ST_INSERTED;
				rsp_q.slot        <= SLOT_W'(idx_q);
				rsp_q.entry_count <= CNT_OUT_W'(count_q + 1'b1);
			end else begin
				rsp_q.status      <= (cmd_q == CMD_INSERT) ? ST_REJECTED : ST_MISS;
				rsp_q.slot        <= '0;
				rsp_q.entry_count <= CNT_OUT_W'(count_q);
			end
		end
	end

	// the count never passes the table depth
	assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W + 1)'(count_q) <= (CNT_W + 1)'(TABLE_DEPTH))
		else $error("entry count above table depth");

	// the store is written only by the clear sweep or an accepted insert
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_CLEAR) || ((state_q == S_CHECK) && (cmd_q == CMD_INSERT)))
		else $error("store written outside clear or insert");

	// a count change always comes with an inserted result
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (done && (rsp.status == ST_INSERTED)))
		else $error("count changed without an insert result");

	// a result follows either an early answer or the end of a probe
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_CHECK) || ($past(state_q) == S_IDLE))
		else $error("result strobe from a wrong state");

endmodule
